FILE: hdl/pdu_pkg.sv
// pdu_pkg: types, register codes, reset values and Q16.16 arithmetic helpers
// for the particle dimension update unit
// no dependencies
package pdu_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CFG_WIDTH = 31;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] TWO_PI_Q = 32'sd411775;
  localparam logic signed [VALUE_WIDTH-1:0] NEG_TWO_PI_Q = -32'sd411775;

  // product magnitude at which any nonzero random already saturates
  localparam logic [47:0] COEF_CLAMP = 48'h8000_0000_0000;

  localparam logic        MODE_RESET           = 1'b0;
  localparam logic [30:0] CONSTRICTION_RESET   = 31'd47829;
  localparam logic [30:0] INERTIA_WEIGHT_RESET = 31'd45875;
  localparam logic [30:0] COEF_PERSONAL_RESET  = 31'd183501;
  localparam logic [30:0] COEF_GLOBAL_RESET    = 31'd85197;
  localparam logic [30:0] COEF_TOTAL_RESET     = 31'd196608;
  localparam logic [30:0] RANK_SCALE_RESET     = 31'd234;
  localparam logic [10:0] PARTICLE_COUNT_RESET = 11'd30;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MODE           = 3'd0,
    REG_CONSTRICTION   = 3'd1,
    REG_INERTIA_WEIGHT = 3'd2,
    REG_COEF_PERSONAL  = 3'd3,
    REG_COEF_GLOBAL    = 3'd4,
    REG_COEF_TOTAL     = 3'd5,
    REG_RANK_SCALE     = 3'd6,
    REG_PARTICLE_COUNT = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    MODE_CONSTRICTION = 1'b0,
    MODE_RANK_INERTIA = 1'b1
  } update_mode_e;

  typedef struct packed {
    update_mode_e mode;
    logic [30:0]  constriction;
    logic [30:0]  inertia_weight;
    logic [30:0]  coef_personal;
    logic [30:0]  coef_global;
    logic [30:0]  coef_total;
    logic [30:0]  rank_scale;
    logic [10:0]  particle_count;
  } cfg_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] position;
    logic signed [VALUE_WIDTH-1:0] velocity;
    logic signed [VALUE_WIDTH-1:0] personal_best;
    logic signed [VALUE_WIDTH-1:0] global_best;
    logic [15:0]                   rand_personal;
    logic [15:0]                   rand_global;
    logic                          is_angle;
    logic [30:0]                   velocity_limit;
    logic [9:0]                    particle_rank;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] new_velocity;
    logic signed [VALUE_WIDTH-1:0] new_position;
  } out_item_t;

  function automatic logic signed [VALUE_WIDTH-1:0] sat_add(
    input logic signed [VALUE_WIDTH-1:0] a,
    input logic signed [VALUE_WIDTH-1:0] b
  );
    logic signed [VALUE_WIDTH:0] s;
    s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
    if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
      return s[VALUE_WIDTH] ? VMIN : VMAX;
    end
    return s[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] sat_neg(
    input logic signed [VALUE_WIDTH-1:0] a
  );
    return (a == VMIN) ? VMAX : -a;
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] magnitude(
    input logic signed [VALUE_WIDTH-1:0] a
  );
    return a[VALUE_WIDTH-1] ? ({VALUE_WIDTH{1'b0}} - $unsigned(a)) : $unsigned(a);
  endfunction

  // round half away from zero on the magnitude, saturate, apply sign
  function automatic logic signed [VALUE_WIDTH-1:0] round_sat(
    input logic [63:0] p,
    input logic        neg
  );
    logic [64:0] s;
    logic [48:0] r;
    logic [48:0] lim;
    logic [VALUE_WIDTH-1:0] rv;
    s   = {1'b0, p} + 65'h8000;
    r   = s[64:16];
    lim = neg ? 49'h0_8000_0000 : 49'h0_7FFF_FFFF;
    if (r > lim) begin
      r = lim;
    end
    rv = r[VALUE_WIDTH-1:0];
    return neg ? $signed({VALUE_WIDTH{1'b0}} - rv) : $signed(rv);
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] qmul(
    input logic signed [VALUE_WIDTH-1:0] a,
    input logic signed [VALUE_WIDTH-1:0] b
  );
    logic [63:0] p;
    p = {32'd0, magnitude(a)} * {32'd0, magnitude(b)};
    return round_sat(p, a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1]);
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] pull_diff(
    input logic signed [VALUE_WIDTH-1:0] best,
    input logic signed [VALUE_WIDTH-1:0] pos,
    input logic                          angle
  );
    logic signed [VALUE_WIDTH-1:0] d1;
    logic signed [VALUE_WIDTH-1:0] d2;
    d1 = sat_add(best, sat_neg(pos));
    d2 = (d1 > 0) ? sat_add(d1, NEG_TWO_PI_Q) : sat_add(d1, TWO_PI_Q);
    if (!angle) begin
      return d1;
    end
    return (magnitude(d1) < magnitude(d2)) ? d1 : d2;
  endfunction

  function automatic logic [47:0] clamp_coef(input logic [55:0] m);
    return (m > {8'd0, COEF_CLAMP}) ? COEF_CLAMP : m[47:0];
  endfunction

endpackage

FILE: hdl/pdu_cfg_regs.sv
// pdu_cfg_regs: configuration register file of the particle dimension update unit
// depends on pdu_pkg
module pdu_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [pdu_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [pdu_pkg::CFG_WIDTH-1:0]         cfg_data,
  output pdu_pkg::cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= pdu_pkg::update_mode_e'(pdu_pkg::MODE_RESET);
      cfg.constriction   <= pdu_pkg::CONSTRICTION_RESET;
      cfg.inertia_weight <= pdu_pkg::INERTIA_WEIGHT_RESET;
      cfg.coef_personal  <= pdu_pkg::COEF_PERSONAL_RESET;
      cfg.coef_global    <= pdu_pkg::COEF_GLOBAL_RESET;
      cfg.coef_total     <= pdu_pkg::COEF_TOTAL_RESET;
      cfg.rank_scale     <= pdu_pkg::RANK_SCALE_RESET;
      cfg.particle_count <= pdu_pkg::PARTICLE_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (pdu_pkg::cfg_reg_e'(cfg_index))
        pdu_pkg::REG_MODE:           cfg.mode <= pdu_pkg::update_mode_e'(cfg_data[0]);
        pdu_pkg::REG_CONSTRICTION:   cfg.constriction <= cfg_data;
        pdu_pkg::REG_INERTIA_WEIGHT: cfg.inertia_weight <= cfg_data;
        pdu_pkg::REG_COEF_PERSONAL:  cfg.coef_personal <= cfg_data;
        pdu_pkg::REG_COEF_GLOBAL:    cfg.coef_global <= cfg_data;
        pdu_pkg::REG_COEF_TOTAL:     cfg.coef_total <= cfg_data;
        pdu_pkg::REG_RANK_SCALE:     cfg.rank_scale <= cfg_data;
        pdu_pkg::REG_PARTICLE_COUNT: cfg.particle_count <= cfg_data[10:0];
      endcase
    end
  end

endmodule

FILE: hdl/pso_particle_dimension_update_unit.sv
// pso_particle_dimension_update_unit: top level, eight-stage Q16.16 velocity
// and position update for one particle coordinate
// depends on pdu_pkg and pdu_cfg_regs
//
// One coordinate beat enters per clock, and throughput is one beat per cycle as long
// as the output is not stalled. The pipeline depth is set by the chain of multiplies
// (rank coefficient, coefficient times random, times pull difference, then the
// constriction product), each with a register behind it. A stalled result beat
// freezes the whole pipeline and holds in_stall high, so no beat is lost or repeated.
// The configuration registers may be written at any time the pipeline holds no beat.
module pso_particle_dimension_update_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pdu_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pdu_pkg::out_item_t                  out_data,
  input  logic                                cfg_write,
  input  logic [pdu_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [pdu_pkg::CFG_WIDTH-1:0]       cfg_data
);

  localparam int VW = pdu_pkg::VALUE_WIDTH;

  pdu_pkg::cfg_t cfg;

  pdu_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic [7:0] valid;
  logic       advance;

  assign advance   = !(valid[7] && out_stall);
  assign in_stall  = !advance;
  assign out_valid = valid[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (advance) begin
      valid <= {valid[6:0], in_valid};
    end
  end

  // stage 1: pull differences, rank term squared
  logic [11:0] s2_size;
  logic [12:0] h_raw;
  logic [11:0] h_clip;
  logic [11:0] t_rank;
  logic [10:0] rank_inc;

  assign rank_inc = {1'b0, in_data.particle_rank} + 11'd1;
  assign s2_size  = {cfg.particle_count, 1'b0};
  assign h_raw    = {1'b0, rank_inc, 1'b0} + {2'b00, cfg.particle_count};
  assign h_clip   = (h_raw > {1'b0, s2_size}) ? s2_size : h_raw[11:0];
  assign t_rank   = s2_size - h_clip;

  logic signed [VW-1:0] st1_dp, st1_dg, st1_pos, st1_vel;
  logic [23:0]          st1_t2;
  logic [15:0]          st1_rp, st1_rg;
  logic [30:0]          st1_lim;

  always_ff @(posedge clk) begin
    if (advance) begin
      st1_dp  <= pdu_pkg::pull_diff(in_data.personal_best, in_data.position, in_data.is_angle);
      st1_dg  <= pdu_pkg::pull_diff(in_data.global_best, in_data.position, in_data.is_angle);
      st1_t2  <= {12'd0, t_rank} * {12'd0, t_rank};
      st1_pos <= in_data.position;
      st1_vel <= in_data.velocity;
      st1_rp  <= in_data.rand_personal;
      st1_rg  <= in_data.rand_global;
      st1_lim <= in_data.velocity_limit;
    end
  end

  // stage 2: rank scale product, inertia product
  logic signed [VW-1:0] st2_dp, st2_dg, st2_pos, st2_vel, st2_wv;
  logic [54:0]          st2_rst2;
  logic [15:0]          st2_rp, st2_rg;
  logic [30:0]          st2_lim;

  always_ff @(posedge clk) begin
    if (advance) begin
      st2_rst2 <= {24'd0, cfg.rank_scale} * {31'd0, st1_t2};
      st2_wv   <= pdu_pkg::qmul($signed({1'b0, cfg.inertia_weight}), st1_vel);
      st2_dp   <= st1_dp;
      st2_dg   <= st1_dg;
      st2_pos  <= st1_pos;
      st2_vel  <= st1_vel;
      st2_rp   <= st1_rp;
      st2_rg   <= st1_rg;
      st2_lim  <= st1_lim;
    end
  end

  // stage 3: coefficient selection and magnitude clamp
  logic [55:0]        cp_sum;
  logic [53:0]        cp_rank;
  logic signed [55:0] cg_rank;
  logic [55:0]        cp_mag, cg_mag;
  logic               cg_neg;

  always_comb begin
    cp_sum  = {1'b0, st2_rst2} + 56'd2;
    cp_rank = cp_sum[55:2];
    cg_rank = $signed({25'd0, cfg.coef_total}) - $signed({2'd0, cp_rank});
    unique case (cfg.mode)
      pdu_pkg::MODE_RANK_INERTIA: begin
        cp_mag = {2'd0, cp_rank};
        cg_neg = cg_rank[55];
        cg_mag = cg_rank[55] ? (56'd0 - $unsigned(cg_rank)) : $unsigned(cg_rank);
      end
      pdu_pkg::MODE_CONSTRICTION: begin
        cp_mag = {25'd0, cfg.coef_personal};
        cg_neg = 1'b0;
        cg_mag = {25'd0, cfg.coef_global};
      end
    endcase
  end

  logic signed [VW-1:0] st3_dp, st3_dg, st3_pos, st3_vel, st3_wv;
  logic [47:0]          st3_cpm, st3_cgm;
  logic                 st3_cg_neg;
  logic [15:0]          st3_rp, st3_rg;
  logic [30:0]          st3_lim;

  always_ff @(posedge clk) begin
    if (advance) begin
      st3_cpm    <= pdu_pkg::clamp_coef(cp_mag);
      st3_cgm    <= pdu_pkg::clamp_coef(cg_mag);
      st3_cg_neg <= cg_neg;
      st3_dp     <= st2_dp;
      st3_dg     <= st2_dg;
      st3_pos    <= st2_pos;
      st3_vel    <= st2_vel;
      st3_wv     <= st2_wv;
      st3_rp     <= st2_rp;
      st3_rg     <= st2_rg;
      st3_lim    <= st2_lim;
    end
  end

  // stage 4: coefficient times random
  logic signed [VW-1:0] st4_cpr, st4_cgr, st4_dp, st4_dg, st4_pos, st4_vel, st4_wv;
  logic [30:0]          st4_lim;

  always_ff @(posedge clk) begin
    if (advance) begin
      st4_cpr <= pdu_pkg::round_sat({16'd0, st3_cpm} * {48'd0, st3_rp}, 1'b0);
      st4_cgr <= pdu_pkg::round_sat({16'd0, st3_cgm} * {48'd0, st3_rg}, st3_cg_neg);
      st4_dp  <= st3_dp;
      st4_dg  <= st3_dg;
      st4_pos <= st3_pos;
      st4_vel <= st3_vel;
      st4_wv  <= st3_wv;
      st4_lim <= st3_lim;
    end
  end

  // stage 5: times pull difference
  logic signed [VW-1:0] st5_pp, st5_gp, st5_pos, st5_vel, st5_wv;
  logic [30:0]          st5_lim;

  always_ff @(posedge clk) begin
    if (advance) begin
      st5_pp  <= pdu_pkg::qmul(st4_cpr, st4_dp);
      st5_gp  <= pdu_pkg::qmul(st4_cgr, st4_dg);
      st5_pos <= st4_pos;
      st5_vel <= st4_vel;
      st5_wv  <= st4_wv;
      st5_lim <= st4_lim;
    end
  end

  // stage 6: sum of pulls
  logic signed [VW-1:0] pulls;
  logic signed [VW-1:0] st6_pulls, st6_vsum, st6_pos, st6_wv;
  logic [30:0]          st6_lim;

  assign pulls = pdu_pkg::sat_add(st5_pp, st5_gp);

  always_ff @(posedge clk) begin
    if (advance) begin
      st6_pulls <= pulls;
      st6_vsum  <= pdu_pkg::sat_add(st5_vel, pulls);
      st6_pos   <= st5_pos;
      st6_wv    <= st5_wv;
      st6_lim   <= st5_lim;
    end
  end

  // stage 7: new velocity and clamp
  logic signed [VW-1:0] nv_raw, nv_clamp, lim_pos, lim_neg;
  logic signed [VW-1:0] st7_nv, st7_pos;

  assign lim_pos = $signed({1'b0, st6_lim});
  assign lim_neg = -lim_pos;

  always_comb begin
    unique case (cfg.mode)
      pdu_pkg::MODE_RANK_INERTIA: nv_raw = pdu_pkg::sat_add(st6_wv, st6_pulls);
      pdu_pkg::MODE_CONSTRICTION: nv_raw = pdu_pkg::qmul($signed({1'b0, cfg.constriction}),
                                                         st6_vsum);
    endcase
    priority if (nv_raw > lim_pos) begin
      nv_clamp = lim_pos;
    end else if (nv_raw < lim_neg) begin
      nv_clamp = lim_neg;
    end else begin
      nv_clamp = nv_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st7_nv  <= nv_clamp;
      st7_pos <= st6_pos;
    end
  end

  // stage 8: new position, output register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.new_velocity <= st7_nv;
      out_data.new_position <= pdu_pkg::sat_add(st7_pos, st7_nv);
    end
  end

endmodule

FILE: verif/tb_pso_particle_dimension_update_unit.sv
// tb_pso_particle_dimension_update_unit: self-checking bench for the particle dimension
// update unit, with a Q16.16 predictor in a small scoreboard class and bursty handshakes
// depends on pdu_pkg and the pso_particle_dimension_update_unit RTL
module tb_pso_particle_dimension_update_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam longint TURN_Q = 64'sd411775;
  localparam logic [30:0] REG_MAX = 31'h7FFF_FFFF;
  localparam logic signed [31:0] VHI = pdu_pkg::VMAX;
  localparam logic signed [31:0] VLO = pdu_pkg::VMIN;
  localparam int LIMIT_CYCLES = 500000;

  class move_checker;
    pdu_pkg::cfg_t cfg;
    pdu_pkg::out_item_t predicted_moves[$];
    int errors;

    function new();
      cfg.mode = pdu_pkg::MODE_CONSTRICTION;
      cfg.constriction = pdu_pkg::CONSTRICTION_RESET;
      cfg.inertia_weight = pdu_pkg::INERTIA_WEIGHT_RESET;
      cfg.coef_personal = pdu_pkg::COEF_PERSONAL_RESET;
      cfg.coef_global = pdu_pkg::COEF_GLOBAL_RESET;
      cfg.coef_total = pdu_pkg::COEF_TOTAL_RESET;
      cfg.rank_scale = pdu_pkg::RANK_SCALE_RESET;
      cfg.particle_count = pdu_pkg::PARTICLE_COUNT_RESET;
      errors = 0;
    endfunction

    function longint clip_word(longint x);
      if (x > WORD_MAX) return WORD_MAX;
      if (x < WORD_MIN) return WORD_MIN;
      return x;
    endfunction

    // exact product, rounded half away from zero, saturated to the word
    function longint fixed_mul(longint a, longint b);
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [127:0] p;
      logic [127:0] r;
      logic [127:0] lim;
      bit           neg;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p = {64'd0, ua} * {64'd0, ub};
      r = (p + 128'h8000) >> 16;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (r > lim) r = lim;
      return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    function longint turn_diff(longint best, longint pos, bit angle);
      longint npos;
      longint d1;
      longint d2;
      longint m1;
      longint m2;
      npos = (pos == WORD_MIN) ? WORD_MAX : -pos;
      d1 = clip_word(best + npos);
      if (!angle) return d1;
      d2 = (d1 > 0) ? clip_word(d1 - TURN_Q) : clip_word(d1 + TURN_Q);
      m1 = (d1 < 0) ? -d1 : d1;
      m2 = (d2 < 0) ? -d2 : d2;
      return (m1 < m2) ? d1 : d2;
    endfunction

    function void predict_move(pdu_pkg::in_item_t it);
      longint pos;
      longint vel;
      longint dp;
      longint dg;
      longint cp;
      longint cg;
      longint pulls;
      longint nv;
      longint np;
      longint lim;
      longint unsigned s2;
      longint unsigned h;
      longint unsigned t;
      pdu_pkg::out_item_t want;
      pos = it.position;
      vel = it.velocity;
      lim = longint'(it.velocity_limit);
      dp = turn_diff(longint'(it.personal_best), pos, it.is_angle);
      dg = turn_diff(longint'(it.global_best), pos, it.is_angle);
      if (cfg.mode == pdu_pkg::MODE_CONSTRICTION) begin
        cp = longint'(cfg.coef_personal);
        cg = longint'(cfg.coef_global);
      end else begin
        s2 = 2 * longint'(cfg.particle_count);
        h = 2 * (longint'(it.particle_rank) + 1) + longint'(cfg.particle_count);
        if (h > s2) h = s2;
        t = s2 - h;
        cp = longint'((longint'(cfg.rank_scale) * t * t + 2) >> 2);
        cg = longint'(cfg.coef_total) - cp;
      end
      pulls = clip_word(fixed_mul(fixed_mul(cp, longint'(it.rand_personal)), dp) +
                        fixed_mul(fixed_mul(cg, longint'(it.rand_global)), dg));
      if (cfg.mode == pdu_pkg::MODE_CONSTRICTION)
        nv = fixed_mul(longint'(cfg.constriction), clip_word(vel + pulls));
      else
        nv = clip_word(fixed_mul(longint'(cfg.inertia_weight), vel) + pulls);
      if (nv > lim) nv = lim;
      if (nv < -lim) nv = -lim;
      np = clip_word(pos + nv);
      want.new_velocity = nv[31:0];
      want.new_position = np[31:0];
      predicted_moves.push_back(want);
    endfunction

    function void check_move(pdu_pkg::out_item_t got);
      pdu_pkg::out_item_t want;
      if (predicted_moves.size() == 0) begin
        $error("result beat with no prediction pending: velocity %0d position %0d",
               got.new_velocity, got.new_position);
        errors++;
        return;
      end
      want = predicted_moves.pop_front();
      if (got.new_velocity !== want.new_velocity) begin
        $error("new_velocity: expected %0d, actual %0d", want.new_velocity, got.new_velocity);
        errors++;
      end
      if (got.new_position !== want.new_position) begin
        $error("new_position: expected %0d, actual %0d", want.new_position, got.new_position);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  pdu_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pdu_pkg::out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [pdu_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = pdu_pkg::REG_MODE;
  logic [pdu_pkg::CFG_WIDTH-1:0] cfg_data = '0;

  move_checker sb = new();
  int cycles = 0;
  int hold_asked = 0;

  pso_particle_dimension_update_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_move(out_data);
  end

  // receiver stall patterns, plus a long hold-off on request
  initial begin : rx_stall
    int kind;
    int left;
    int hold;
    int served;
    kind = 0;
    left = 0;
    hold = 0;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_asked != served) begin
        served = hold_asked;
        hold = 150;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        if (left == 0) begin
          kind = $urandom_range(0, 3);
          left = $urandom_range(4, 80);
        end
        left--;
        case (kind)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= (left % 5 == 0);
        endcase
      end
    end
  end

  function automatic pdu_pkg::in_item_t mk(int pos, int vel, int pb, int gb, int rp, int rg,
                                           bit ang, logic [30:0] lim, int rank);
    pdu_pkg::in_item_t it;
    it.position = pos;
    it.velocity = vel;
    it.personal_best = pb;
    it.global_best = gb;
    it.rand_personal = rp[15:0];
    it.rand_global = rg[15:0];
    it.is_angle = ang;
    it.velocity_limit = lim;
    it.particle_rank = rank[9:0];
    return it;
  endfunction

  function automatic logic signed [31:0] pick_value(int near);
    case ($urandom_range(0, 9))
      0: return VLO;
      1: return VHI;
      2, 3: return $urandom;
      default: return near + int'($urandom_range(0, 1200000)) - 600000;
    endcase
  endfunction

  function automatic logic [15:0] pick_rand();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [30:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return 31'd0;
      1: return REG_MAX;
      2: return 31'($urandom);
      default: return 31'($urandom_range(0, 4 * 65536));
    endcase
  endfunction

  function automatic pdu_pkg::in_item_t rand_item();
    pdu_pkg::in_item_t it;
    it.position = pick_value(0);
    it.velocity = pick_value(0);
    it.personal_best = pick_value(it.position);
    it.global_best = pick_value(it.position);
    it.rand_personal = pick_rand();
    it.rand_global = pick_rand();
    it.is_angle = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: it.velocity_limit = 31'd0;
      1: it.velocity_limit = REG_MAX;
      2, 3, 4: it.velocity_limit = 31'($urandom);
      default: it.velocity_limit = 31'($urandom_range(0, 4 * 65536));
    endcase
    if ($urandom_range(0, 1))
      it.particle_rank = 10'($urandom_range(0, 1023));
    else
      it.particle_rank = 10'($urandom_range(0, sb.cfg.particle_count > 1023 ? 1023 :
                                                 sb.cfg.particle_count));
    return it;
  endfunction

  function automatic pdu_pkg::cfg_t rand_cfg();
    pdu_pkg::cfg_t c;
    c.mode = pdu_pkg::update_mode_e'($urandom_range(0, 1));
    c.constriction = pick_coef();
    c.inertia_weight = pick_coef();
    c.coef_personal = pick_coef();
    c.coef_global = pick_coef();
    c.coef_total = pick_coef();
    case ($urandom_range(0, 9))
      0: c.rank_scale = 31'd0;
      1: c.rank_scale = REG_MAX;
      default: c.rank_scale = 31'($urandom_range(0, 3000));
    endcase
    case ($urandom_range(0, 5))
      0: c.particle_count = 11'd2;
      1: c.particle_count = 11'd1024;
      2: c.particle_count = 11'($urandom_range(2, 1024));
      default: c.particle_count = 11'($urandom_range(2, 64));
    endcase
    return c;
  endfunction

  task automatic send_beat(pdu_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.predict_move(it);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.predicted_moves.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic put_reg(pdu_pkg::cfg_reg_e idx, logic [30:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(pdu_pkg::cfg_t c);
    put_reg(pdu_pkg::REG_MODE, {30'd0, c.mode});
    put_reg(pdu_pkg::REG_CONSTRICTION, c.constriction);
    put_reg(pdu_pkg::REG_INERTIA_WEIGHT, c.inertia_weight);
    put_reg(pdu_pkg::REG_COEF_PERSONAL, c.coef_personal);
    put_reg(pdu_pkg::REG_COEF_GLOBAL, c.coef_global);
    put_reg(pdu_pkg::REG_COEF_TOTAL, c.coef_total);
    put_reg(pdu_pkg::REG_RANK_SCALE, c.rank_scale);
    put_reg(pdu_pkg::REG_PARTICLE_COUNT, {20'd0, c.particle_count});
    cfg_write <= 1'b0;
    sb.cfg = c;
  endtask

  task automatic run_random(int count, bit gaps);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) send_beat(rand_item());
      left -= burst;
      if (gaps && $urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
    end
  endtask

  initial begin : main
    pdu_pkg::in_item_t directed[$];
    pdu_pkg::cfg_t c;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // constriction mode at reset settings
    directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 31'd0, 0));
    directed.push_back(mk(65536, 65536, 131072, 196608, 32768, 32768, 0, REG_MAX, 0));
    directed.push_back(mk(VLO, VHI, -1, VHI, 65535, 65535, 0, REG_MAX, 0));
    directed.push_back(mk(VHI, VLO, VLO, VLO, 65535, 65535, 0, REG_MAX, 1023));
    directed.push_back(mk(0, 100, 205887, 205888, 65535, 65535, 1, REG_MAX, 0));
    directed.push_back(mk(0, 0, 1000000, -1000000, 40000, 50000, 1, REG_MAX, 0));
    directed.push_back(mk(100000, 0, -300000, 400000, 65535, 0, 1, REG_MAX, 0));
    directed.push_back(mk(VLO, 0, VHI, 0, 65535, 65535, 1, REG_MAX, 0));
    directed.push_back(mk(5, 1000, 70000, 80000, 65535, 65535, 0, 31'd0, 0));
    directed.push_back(mk(0, VHI, VHI, VHI, 65535, 65535, 0, 31'd1000, 0));
    directed.push_back(mk(0, VLO, VLO, VLO, 65535, 65535, 0, 31'd1000, 0));
    directed.push_back(mk(VHI, 65536, VHI, VHI, 1, 1, 0, REG_MAX, 0));
    directed.push_back(mk(VLO, -65536, VLO, VLO, 1, 1, 0, REG_MAX, 0));
    directed.push_back(mk(3, -7, 32771, -32765, 1, 32768, 0, REG_MAX, 0));
    foreach (directed[i]) send_beat(directed[i]);
    drain();

    // rank inertia mode, rank edges around the swarm size
    c = sb.cfg;
    c.mode = pdu_pkg::MODE_RANK_INERTIA;
    apply_config(c);
    directed.delete();
    directed.push_back(mk(0, 65536, 131072, -131072, 65535, 65535, 0, REG_MAX, 0));
    directed.push_back(mk(0, 65536, 131072, -131072, 65535, 65535, 0, REG_MAX, 1));
    directed.push_back(mk(0, 65536, 131072, -131072, 65535, 65535, 0, REG_MAX, 14));
    directed.push_back(mk(0, 65536, 131072, -131072, 65535, 65535, 0, REG_MAX, 15));
    directed.push_back(mk(0, 65536, 131072, -131072, 65535, 65535, 0, REG_MAX, 28));
    directed.push_back(mk(0, 65536, 131072, -131072, 65535, 65535, 0, REG_MAX, 29));
    directed.push_back(mk(0, 65536, 131072, -131072, 65535, 65535, 0, REG_MAX, 30));
    directed.push_back(mk(300000, -65536, -300000, 300000, 32768, 32768, 1, REG_MAX, 1023));
    directed.push_back(mk(VLO, VHI, VHI, -1, 65535, 65535, 1, 31'd0, 0));
    directed.push_back(mk(VHI, VLO, VLO, VHI, 65535, 65535, 0, 31'd65536, 511));
    foreach (directed[i]) send_beat(directed[i]);
    drain();

    // register extremes
    c.mode = pdu_pkg::MODE_CONSTRICTION;
    c.constriction = REG_MAX;
    c.inertia_weight = REG_MAX;
    c.coef_personal = REG_MAX;
    c.coef_global = REG_MAX;
    c.coef_total = REG_MAX;
    c.rank_scale = REG_MAX;
    c.particle_count = 11'd1024;
    apply_config(c);
    run_random(50, 1'b1);
    drain();
    c.mode = pdu_pkg::MODE_RANK_INERTIA;
    apply_config(c);
    run_random(50, 1'b0);
    drain();
    c = '0;
    c.mode = pdu_pkg::MODE_RANK_INERTIA;
    c.particle_count = 11'd2;
    apply_config(c);
    run_random(50, 1'b1);
    drain();
    c.mode = pdu_pkg::MODE_CONSTRICTION;
    c.particle_count = 11'd1024;
    apply_config(c);
    run_random(50, 1'b1);
    drain();

    for (int phase = 0; phase < 11; phase++) begin
      apply_config(rand_cfg());
      if (phase == 3 || phase == 8) hold_asked++;
      run_random(150, phase % 4 != 1);
      drain();
    end

    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
